>>> rtl/bod_pkg.sv
// Shared types and constants for the byte offset delta decoder.
package bod_pkg;

  localparam int unsigned CountWidth = 27;
  localparam int unsigned ValueWidth = 32;

  // Escape codes of the byte offset stream
  localparam logic [7:0]  ESCAPE_BYTE = 8'h80;
  localparam logic [15:0] ESCAPE_WORD = 16'h8000;

  // One decoded result word
  typedef struct packed {
    logic                         pixel_valid;
    logic signed [ValueWidth-1:0] pixel_value;
    logic                         last_pixel;
    logic                         short_frame;
  } result_t;

endpackage

>>> rtl/bod_if.sv
// Valid/ready channel interfaces for compressed bytes and decoded pixels.
interface bod_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface bod_pixel_if;
  logic               valid;
  logic               ready;
  logic               pixel_valid;
  logic signed [31:0] pixel_value;
  logic               last_pixel;
  logic               short_frame;

  modport source (output valid, output pixel_valid, output pixel_value,
                  output last_pixel, output short_frame, input ready);
  modport sink (input valid, input pixel_valid, input pixel_value,
                input last_pixel, input short_frame, output ready);
endinterface

>>> rtl/byte_offset_delta_decoder.sv
// Top level of the byte offset delta decoder.
// Usage:
//   byte_in carries one compressed byte per word, with end_of_data on the
//   final byte of a frame. pixel_out carries zero or one result word per
//   byte: a decoded pixel (running sum of deltas), with last_pixel on the
//   pixel that completes the frame, and/or short_frame when data ended early.
//   Escape bytes give no word; bytes after the frame is complete are dropped
//   until end of data, which always restarts the frame at value zero.
//   cfg_we/cfg_data write pixel_count (reset value 1); write only when idle.
// Timing:
//   One byte is accepted every cycle while byte_in.ready is high. The
//   decode is a single add and count compare between the frame state
//   registers and the output buffer, which registers each result word.
// Reset and stall:
//   rst (synchronous) clears the frame state and empties the output buffer.
//   When pixel_out stalls, one further word is held in a skid register;
//   byte_in.ready drops only while that skid register is occupied.
module byte_offset_delta_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [26:0] cfg_data,
  bod_byte_if.sink    byte_in,
  bod_pixel_if.source pixel_out
);
  import bod_pkg::*;

  logic [CountWidth-1:0] pixel_count;
  logic                  room;
  logic                  take;
  logic                  res_push;
  result_t               res;

  // Hold the frame size register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count <= CountWidth'(1);
    end else if (cfg_we) begin
      pixel_count <= cfg_data;
    end
  end

  assign byte_in.ready = room;
  assign take          = byte_in.valid && room;

  bod_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .data_byte   (byte_in.data_byte),
    .end_of_data (byte_in.end_of_data),
    .pixel_count (pixel_count),
    .res_push    (res_push),
    .res         (res)
  );

  bod_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res),
    .room      (room),
    .pixel_out (pixel_out)
  );

endmodule

>>> rtl/bod_decode.sv
// Escape decoding, running sum and frame pixel count.
module bod_decode (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                take,
  input  logic [7:0]                          data_byte,
  input  logic                                end_of_data,
  input  logic [bod_pkg::CountWidth-1:0]      pixel_count,
  output logic                                res_push,
  output bod_pkg::result_t                    res
);
  import bod_pkg::*;

  typedef enum logic [2:0] {
    PH_CODE = 3'd0,
    PH_W0   = 3'd1,
    PH_W1   = 3'd2,
    PH_L0   = 3'd3,
    PH_L1   = 3'd4,
    PH_L2   = 3'd5,
    PH_L3   = 3'd6
  } phase_t;

  phase_t                  phase, phase_next;
  logic [23:0]             assembly, assembly_next;
  logic [ValueWidth-1:0]   running;
  logic [CountWidth-1:0]   count;
  logic                    complete;

  logic                    dvalid;
  logic [ValueWidth-1:0]   delta;
  logic [15:0]             word;
  logic [ValueWidth-1:0]   sum;
  logic [CountWidth-1:0]   count_inc;
  logic                    hit;
  logic                    short_f;

  // Decode one byte against the escape phase
  always_comb begin
    dvalid        = 1'b0;
    delta         = '0;
    phase_next    = phase;
    assembly_next = assembly;
    word          = {data_byte, assembly[7:0]};
    if (!complete) begin
      unique case (phase)
        PH_CODE: begin
          if (data_byte == ESCAPE_BYTE) begin
            phase_next = PH_W0;
          end else begin
            delta  = {{(ValueWidth-8){data_byte[7]}}, data_byte};
            dvalid = 1'b1;
          end
        end
        PH_W0: begin
          assembly_next[7:0] = data_byte;
          phase_next         = PH_W1;
        end
        PH_W1: begin
          if (word == ESCAPE_WORD) begin
            phase_next = PH_L0;
          end else begin
            delta      = {{(ValueWidth-16){word[15]}}, word};
            dvalid     = 1'b1;
            phase_next = PH_CODE;
          end
        end
        PH_L0: begin
          assembly_next[7:0] = data_byte;
          phase_next         = PH_L1;
        end
        PH_L1: begin
          assembly_next[15:8] = data_byte;
          phase_next          = PH_L2;
        end
        PH_L2: begin
          assembly_next[23:16] = data_byte;
          phase_next           = PH_L3;
        end
        PH_L3: begin
          delta      = {data_byte, assembly};
          dvalid     = 1'b1;
          phase_next = PH_CODE;
        end
        default: phase_next = PH_CODE;
      endcase
    end
  end

  // Accumulate and test for the end of the frame
  assign sum       = running + delta;
  assign count_inc = count + 1'b1;
  assign hit       = dvalid && (count_inc == pixel_count);
  assign short_f   = end_of_data && !(complete || hit);

  assign res_push        = take && (dvalid || short_f);
  assign res.pixel_valid = dvalid;
  assign res.pixel_value = dvalid ? sum : '0;
  assign res.last_pixel  = hit;
  assign res.short_frame = short_f;

  // Hold frame state; end of data starts a fresh frame
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_CODE;
      running  <= '0;
      count    <= '0;
      complete <= 1'b0;
    end else if (take) begin
      if (end_of_data) begin
        phase    <= PH_CODE;
        running  <= '0;
        count    <= '0;
        complete <= 1'b0;
      end else begin
        phase <= phase_next;
        if (dvalid) begin
          running <= sum;
          count   <= count_inc;
        end
        if (hit) begin
          complete <= 1'b1;
        end
      end
    end
  end

  // Gathered escape bytes need no reset
  always_ff @(posedge clk) begin
    if (take) begin
      assembly <= assembly_next;
    end
  end

  a_last_has_pixel: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.last_pixel) |-> res.pixel_valid)
    else $error("last pixel flagged without a pixel");

  a_eod_clears: assert property (@(posedge clk) disable iff (rst)
    (take && end_of_data) |=> (phase == PH_CODE && count == '0 && !complete))
    else $error("frame state not cleared after end of data");

  a_complete_quiet: assert property (@(posedge clk) disable iff (rst)
    complete |-> !dvalid)
    else $error("pixel decoded on a complete frame");

endmodule

>>> rtl/bod_out_buf.sv
// Two-entry output register with skid stage for decoded result words.
module bod_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bod_pkg::result_t push_data,
  output logic             room,
  bod_pixel_if.source      pixel_out
);
  import bod_pkg::*;

  logic    main_valid, skid_valid;
  result_t main, skid;
  logic    pop;

  assign pop  = main_valid && pixel_out.ready;
  assign room = !skid_valid;

  assign pixel_out.valid       = main_valid;
  assign pixel_out.pixel_valid = main.pixel_valid;
  assign pixel_out.pixel_value = main.pixel_value;
  assign pixel_out.last_pixel  = main.last_pixel;
  assign pixel_out.short_frame = main.short_frame;

  // Advance the skid word or a new word into the output register, or park a new word in the skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (!main_valid || pop) begin
      main <= skid_valid ? skid : push_data;
    end else if (push) begin
      skid <= push_data;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid word held with empty output register");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(push && skid_valid))
    else $error("word pushed into a full buffer");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && pop) |=> (main_valid && !skid_valid))
    else $error("skid word lost on drain");

endmodule
